// File: hdl/hdv_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and layout positions for the HTTP date checker.
// No dependencies; used by hdv_scan and http_date_validator.
package hdv_pkg;

	typedef logic [4:0] pos_t;
	typedef logic [7:0] char_t;
	typedef logic [6:0] num_t;
	typedef logic [3:0] month_t;

	// One scan register set, carried from one beat to the next.
	typedef struct packed {
		pos_t        pos;
		logic        reject;
		logic [15:0] letters;
		num_t        day;
		month_t      month;
		num_t        year_hi;
		num_t        year_lo;
		num_t        pair;
	} scan_state_t;

	// Layout positions of the 29-character date.
	localparam pos_t P_WDAY0 = 5'd0;
	localparam pos_t P_WDAY1 = 5'd1;
	localparam pos_t P_WDAY2 = 5'd2;
	localparam pos_t P_COMMA = 5'd3;
	localparam pos_t P_SP0   = 5'd4;
	localparam pos_t P_DAY0  = 5'd5;
	localparam pos_t P_DAY1  = 5'd6;
	localparam pos_t P_SP1   = 5'd7;
	localparam pos_t P_MON0  = 5'd8;
	localparam pos_t P_MON1  = 5'd9;
	localparam pos_t P_MON2  = 5'd10;
	localparam pos_t P_SP2   = 5'd11;
	localparam pos_t P_YEAR0 = 5'd12;
	localparam pos_t P_YEAR1 = 5'd13;
	localparam pos_t P_YEAR2 = 5'd14;
	localparam pos_t P_YEAR3 = 5'd15;
	localparam pos_t P_SP3   = 5'd16;
	localparam pos_t P_HOUR0 = 5'd17;
	localparam pos_t P_HOUR1 = 5'd18;
	localparam pos_t P_COL0  = 5'd19;
	localparam pos_t P_MIN0  = 5'd20;
	localparam pos_t P_MIN1  = 5'd21;
	localparam pos_t P_COL1  = 5'd22;
	localparam pos_t P_SEC0  = 5'd23;
	localparam pos_t P_SEC1  = 5'd24;
	localparam pos_t P_SP4   = 5'd25;
	localparam pos_t P_ZONE0 = 5'd26;
	localparam pos_t P_ZONE1 = 5'd27;
	localparam pos_t P_ZONE2 = 5'd28;
	localparam pos_t P_FULL  = 5'd29;

	localparam char_t CH_COMMA = 8'h2C;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_COLON = 8'h3A;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_G     = 8'h47;
	localparam char_t CH_M     = 8'h4D;
	localparam char_t CH_T     = 8'h54;

	localparam num_t MAX_HOUR = 7'd23;
	localparam num_t MAX_MINSEC = 7'd59;

	localparam logic [23:0] WEEKDAY_NAMES [7] = '{
		"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"
	};

	localparam logic [23:0] MONTH_NAMES [12] = '{
		"Jan", "Feb", "Mar", "Apr", "May", "Jun",
		"Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
	};

	function automatic logic weekday_ok(input logic [23:0] word);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 7; i++) begin
			if (WEEKDAY_NAMES[i] == word) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// 1..12 for a known month name, 0 otherwise.
	function automatic month_t month_code(input logic [23:0] word);
		month_t code;
		code = '0;
		for (int i = 0; i < 12; i++) begin
			if (MONTH_NAMES[i] == word) begin
				code = month_t'(i + 1);
			end
		end
		return code;
	endfunction

	function automatic logic [4:0] month_days(input month_t m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
			4'd2:                                      n = leap ? 5'd29 : 5'd28;
			default:                                   n = 5'd0;
		endcase
		return n;
	endfunction

	// x * 10 + d, kept to seven bits.
	function automatic num_t times10_add(input num_t x, input logic [3:0] d);
		return num_t'({x, 3'b000} + {x, 1'b0} + {3'b000, d});
	endfunction

endpackage

// File: hdl/http_date_validator.sv
`timescale 1ns / 1ps
// HTTP (RFC 1123) date checker, one character per beat; depends on hdv_pkg, hdv_scan.
// Throughput: one byte per cycle while no result waits; the scan state updates in a single pass of hdv_scan.
// date_ok is registered as the final byte leaves the input register into the scan.
// A waiting result stalls input only once the next final byte reaches the input register.
// Reset (arst_n low) clears the scan state and both valid flags; no result is pending.
module http_date_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       date_ok
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 advance;
	logic                 out_valid_q;
	logic                 date_ok_q;
	hdv_pkg::scan_state_t state_q;
	hdv_pkg::scan_state_t state_nxt;

	hdv_scan u_scan (
		.cur     (state_q),
		.in_char (byte_s1),
		.nxt     (state_nxt)
	);

	// a final byte waits only when the result register is still full and not being read
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= last_s1 ? '0 : state_nxt;
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
		if (advance && last_s1) begin
			date_ok_q <= !state_nxt.reject && (state_q.pos == hdv_pkg::P_ZONE2);
		end
	end

	assign out_valid = out_valid_q;
	assign date_ok   = date_ok_q;

endmodule

// File: hdl/hdv_scan.sv
`timescale 1ns / 1ps
// Per-beat date layout check: next scan state from the current state and one byte.
// Depends on hdv_pkg.
module hdv_scan (
	input  hdv_pkg::scan_state_t cur,
	input  hdv_pkg::char_t       in_char,
	output hdv_pkg::scan_state_t nxt
);

	logic            dig;
	logic [3:0]      dval;
	logic [23:0]     word;
	hdv_pkg::num_t   acc_day;
	hdv_pkg::num_t   acc_year_hi;
	hdv_pkg::num_t   acc_year_lo;
	hdv_pkg::num_t   acc_pair;
	hdv_pkg::month_t mcode;
	logic            leap;
	logic            year_zero;
	logic [4:0]      lim;
	logic            bad;

	assign dig  = (in_char >= hdv_pkg::CH_ZERO) && (in_char <= hdv_pkg::CH_NINE);
	assign dval = dig ? 4'(in_char - hdv_pkg::CH_ZERO) : 4'd0;
	assign word = {cur.letters, in_char};

	assign acc_day     = hdv_pkg::times10_add(cur.day, dval);
	assign acc_year_hi = hdv_pkg::times10_add(cur.year_hi, dval);
	assign acc_year_lo = hdv_pkg::times10_add(cur.year_lo, dval);
	assign acc_pair    = hdv_pkg::times10_add(cur.pair, dval);
	assign mcode       = hdv_pkg::month_code(word);

	// Gregorian leap year from the century and the low two digits.
	assign leap = (acc_year_lo[1:0] == 2'b00)
		&& ((acc_year_lo != '0) || (cur.year_hi[1:0] == 2'b00));
	assign year_zero = (cur.year_hi == '0) && (acc_year_lo == '0);
	assign lim = hdv_pkg::month_days(cur.month, leap);

	always_comb begin
		nxt = cur;
		bad = 1'b0;
		case (cur.pos)
			hdv_pkg::P_WDAY0, hdv_pkg::P_WDAY1, hdv_pkg::P_MON0, hdv_pkg::P_MON1: begin
				nxt.letters = word[15:0];
			end
			hdv_pkg::P_WDAY2: bad = !hdv_pkg::weekday_ok(word);
			hdv_pkg::P_COMMA: bad = (in_char != hdv_pkg::CH_COMMA);
			hdv_pkg::P_SP0, hdv_pkg::P_SP1, hdv_pkg::P_SP2, hdv_pkg::P_SP3,
			hdv_pkg::P_SP4: begin
				bad = (in_char != hdv_pkg::CH_SPACE);
			end
			hdv_pkg::P_COL0, hdv_pkg::P_COL1: bad = (in_char != hdv_pkg::CH_COLON);
			hdv_pkg::P_DAY0, hdv_pkg::P_DAY1: begin
				bad = !dig;
				if (dig) begin
					nxt.day = acc_day;
				end
			end
			hdv_pkg::P_MON2: begin
				nxt.month = mcode;
				bad = (mcode == '0);
			end
			hdv_pkg::P_YEAR0, hdv_pkg::P_YEAR1: begin
				bad = !dig;
				if (dig) begin
					nxt.year_hi = acc_year_hi;
				end
			end
			hdv_pkg::P_YEAR2: begin
				bad = !dig;
				if (dig) begin
					nxt.year_lo = acc_year_lo;
				end
			end
			hdv_pkg::P_YEAR3: begin
				if (!dig) begin
					bad = 1'b1;
				end else begin
					nxt.year_lo = acc_year_lo;
					bad = year_zero || (cur.month == '0) || (cur.day == '0)
						|| (cur.day > {2'b00, lim});
				end
			end
			hdv_pkg::P_HOUR0, hdv_pkg::P_MIN0, hdv_pkg::P_SEC0: begin
				bad = !dig;
				if (dig) begin
					nxt.pair = {3'b000, dval};
				end
			end
			hdv_pkg::P_HOUR1: begin
				bad = !dig || (acc_pair > hdv_pkg::MAX_HOUR);
				if (dig) begin
					nxt.pair = acc_pair;
				end
			end
			hdv_pkg::P_MIN1, hdv_pkg::P_SEC1: begin
				bad = !dig || (acc_pair > hdv_pkg::MAX_MINSEC);
				if (dig) begin
					nxt.pair = acc_pair;
				end
			end
			hdv_pkg::P_ZONE0: bad = (in_char != hdv_pkg::CH_G);
			hdv_pkg::P_ZONE1: bad = (in_char != hdv_pkg::CH_M);
			hdv_pkg::P_ZONE2: bad = (in_char != hdv_pkg::CH_T);
			default:          bad = 1'b1;
		endcase
		nxt.reject = cur.reject || bad;
		// hold the position at full length once past the end
		if (cur.pos < hdv_pkg::P_FULL) begin
			nxt.pos = cur.pos + 5'd1;
		end
	end

endmodule
